### hdl/jsu_pkg.sv
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_CONTROL = 2'd0,
        ERR_ESCAPE  = 2'd1,
        ERR_HEX     = 2'd2
    } err_t;

    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]                   cnt;
        kind_t                        kind;
        err_t                         err;
        logic [MAX_RESULTS-1:0][7:0]  data;
    } group_t;

endpackage

### hdl/jsu_decode.sv
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output group_t     grp
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [2:0] PHASE_LAST = 3'd4;

    logic        in_escape_reg, in_escape_next;
    logic [2:0]  hex_phase_reg, hex_phase_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic        hex_bad_reg, hex_bad_next;

    logic [3:0]  hval;
    logic        hok;
    logic [15:0] acc_new;
    logic        bad_new;

    always_comb begin
        hok  = 1'b1;
        hval = 4'd0;
        if (in_byte inside {[8'h30:8'h39]}) begin
            hval = in_byte[3:0];
        end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hval = in_byte[3:0] + 4'd9;
        end else begin
            hok = 1'b0;
        end
    end

    assign acc_new = {hex_accum_reg[11:0], hval};
    assign bad_new = hex_bad_reg | ~hok;

    always_comb begin
        in_escape_next = in_escape_reg;
        hex_phase_next = hex_phase_reg;
        hex_accum_next = hex_accum_reg;
        hex_bad_next   = hex_bad_reg;
        grp.cnt  = 2'd0;
        grp.kind = KIND_DATA;
        grp.err  = ERR_CONTROL;
        grp.data = '0;
        if (hex_phase_reg != 3'd0) begin
            hex_accum_next = acc_new;
            hex_bad_next   = bad_new;
            if (hex_phase_reg < PHASE_LAST) begin
                hex_phase_next = hex_phase_reg + 3'd1;
            end else begin
                in_escape_next = 1'b0;
                hex_phase_next = 3'd0;
                hex_accum_next = '0;
                hex_bad_next   = 1'b0;
                if (bad_new) begin
                    grp.cnt  = 2'd1;
                    grp.kind = KIND_ERROR;
                    grp.err  = ERR_HEX;
                end else if (acc_new[15:7] == '0) begin
                    grp.cnt     = 2'd1;
                    grp.data[0] = {1'b0, acc_new[6:0]};
                end else if (acc_new[15:11] == '0) begin
                    grp.cnt     = 2'd2;
                    grp.data[0] = {3'b110, acc_new[10:6]};
                    grp.data[1] = {2'b10, acc_new[5:0]};
                end else begin
                    grp.cnt     = 2'd3;
                    grp.data[0] = {4'b1110, acc_new[15:12]};
                    grp.data[1] = {2'b10, acc_new[11:6]};
                    grp.data[2] = {2'b10, acc_new[5:0]};
                end
            end
        end else if (in_escape_reg) begin
            in_escape_next = 1'b0;
            grp.cnt        = 2'd1;
            case (in_byte)
                CH_QUOTE, CH_SLASH, CH_BSL: grp.data[0] = in_byte;
                CH_B: grp.data[0] = 8'h08;
                CH_F: grp.data[0] = 8'h0c;
                CH_N: grp.data[0] = 8'h0a;
                CH_R: grp.data[0] = 8'h0d;
                CH_T: grp.data[0] = 8'h09;
                CH_U: begin
                    grp.cnt        = 2'd0;
                    hex_phase_next = 3'd1;
                    hex_accum_next = '0;
                    hex_bad_next   = 1'b0;
                end
                default: begin
                    grp.kind       = KIND_ERROR;
                    grp.err        = ERR_ESCAPE;
                    hex_accum_next = '0;
                    hex_bad_next   = 1'b0;
                end
            endcase
        end else if (in_byte == CH_BSL) begin
            in_escape_next = 1'b1;
        end else if (in_byte == CH_QUOTE) begin
            grp.cnt        = 2'd1;
            grp.kind       = KIND_END;
            hex_accum_next = '0;
            hex_bad_next   = 1'b0;
        end else if (in_byte < 8'h20) begin
            grp.cnt        = 2'd1;
            grp.kind       = KIND_ERROR;
            grp.err        = ERR_CONTROL;
            hex_accum_next = '0;
            hex_bad_next   = 1'b0;
        end else begin
            grp.cnt     = 2'd1;
            grp.data[0] = in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_escape_reg <= 1'b0;
            hex_phase_reg <= 3'd0;
            hex_accum_reg <= '0;
            hex_bad_reg   <= 1'b0;
        end else if (accept) begin
            in_escape_reg <= in_escape_next;
            hex_phase_reg <= hex_phase_next;
            hex_accum_reg <= hex_accum_next;
            hex_bad_reg   <= hex_bad_next;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hex_phase_reg <= PHASE_LAST)
        else $error("hex phase out of range");

    a_escape_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_escape_reg && hex_phase_reg != 3'd0))
        else $error("escape and hex phase both open");

    a_hex_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_escape_reg && in_byte == CH_U |=> hex_phase_reg == 3'd1)
        else $error("unicode escape did not open hex phase");

endmodule

### hdl/jsu_emit.sv
module jsu_emit
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  group_t     grp_in,
    output logic       take,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [1:0] m_error_code,
    output logic       m_last
);

    group_t     grp_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;

    assign m_valid      = valid_reg;
    assign m_kind       = grp_reg.kind;
    assign m_error_code = grp_reg.err;
    assign m_data_byte  = grp_reg.data[idx_reg];
    assign m_last       = (idx_reg == grp_reg.cnt - 2'd1);
    assign take         = !valid_reg || (m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (take) begin
            valid_reg <= load && (grp_in.cnt != 2'd0);
            idx_reg   <= 2'd0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && load) begin
            grp_reg <= grp_in;
        end
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> idx_reg < grp_reg.cnt)
        else $error("result index beyond group");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && grp_reg.kind != KIND_DATA |-> grp_reg.cnt == 2'd1)
        else $error("end or error group holds more than one result");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_ready && !m_last |=> valid_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("group did not advance");

endmodule

### hdl/json_string_unescape_top.sv
// The first result of a byte is registered and valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while m_ready is high; m_ready low holds s_ready low, and a
// \u escape that yields two or three UTF-8 bytes holds it low while the result register drains.
// Bytes that give no result (backslash, the u of an escape, first three hex digits) raise no result valid.
// Reset: synchronous, active low; clears the decoder state and the result valid.
module json_string_unescape_top
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [1:0] m_error_code,
    output logic       m_last
);

    group_t grp;
    logic   take;
    logic   accept;

    assign s_ready = take;
    assign accept  = s_valid && take;

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .grp     (grp)
    );

    jsu_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .grp_in       (grp),
        .take         (take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

endmodule
